FILE: hdl/two_line_pulse_packet_receiver_macros.svh
// Assertion macros for the two-line pulse packet receiver.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TWO_LINE_PULSE_PACKET_RECEIVER_MACROS_SVH
`define TWO_LINE_PULSE_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tlpr_pkg.sv
// Shared types, command codes and helpers of the two-line pulse packet receiver.
// No dependencies.
`timescale 1ns / 1ps

package tlpr_pkg;

    localparam int unsigned PACKET_BITS = 128;
    localparam int unsigned BIT_CNT_W   = $clog2(PACKET_BITS);

    // Bit position of the last bit of a packet
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PACKET_BITS - 1);

    localparam logic [4:0] CMD_MULTI_PLAYER = 5'h11;
    localparam logic [4:0] CMD_MASK_ENABLE  = 5'h17;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;

    localparam logic [1:0] LINES_BOTH_LOW  = 2'b00;
    localparam logic [1:0] LINES_SEND_ONE  = 2'b01;
    localparam logic [1:0] LINES_SEND_ZERO = 2'b10;
    localparam logic [1:0] LINES_BOTH_HIGH = 2'b11;

    localparam logic [3:0] INDEX_INVERT = 4'hF;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        packet_valid;
        logic [63:0] packet_low;
        logic [63:0] packet_high;
        logic [2:0]  packet_number;
        logic        sequence_done;
        logic [4:0]  command_id;
        logic [2:0]  active_players;
        logic [1:0]  screen_mask;
    } t_result;

    // Player count from the multi-player code; the undefined code gives one.
    function automatic logic [2:0] player_count_of(input logic [1:0] code);
        logic [2:0] pc;
        unique case (code)
            2'd1:    pc = 3'd2;
            2'd3:    pc = 3'd4;
            default: pc = 3'd1;
        endcase
        return pc;
    endfunction

endpackage

FILE: hdl/tlpr_core.sv
// Receive state and next-state logic of the two-line pulse packet receiver.
// Depends on tlpr_pkg.
`timescale 1ns / 1ps

module tlpr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_take,
    input  logic               i_opcode,
    input  logic [7:0]         i_joyp_value,
    output tlpr_pkg::t_result  o_result
);

    logic                                  r_enabled;
    logic [1:0]                            r_prev_lines, n_prev_lines;
    logic                                  r_receiving, n_receiving;
    logic [tlpr_pkg::BIT_CNT_W-1:0]        r_bit_count, n_bit_count;
    logic [tlpr_pkg::PACKET_BITS-1:0]      r_packet, n_packet;
    logic [2:0]                            r_seq_total, n_seq_total;
    logic [2:0]                            r_seq_count, n_seq_count;
    logic [4:0]                            r_seq_cmd, n_seq_cmd;
    logic [7:0]                            r_seq_arg, n_seq_arg;
    logic [2:0]                            r_player_count, n_player_count;
    logic [1:0]                            r_player_index, n_player_index;
    logic [1:0]                            r_mask, n_mask;

    logic [1:0]                            lines;
    logic [1:0]                            idx;
    logic                                  bit_val;
    logic [tlpr_pkg::PACKET_BITS-1:0]      bits;
    logic [2:0]                            v_total;
    logic [2:0]                            v_count;

    always_comb begin
        n_prev_lines   = r_prev_lines;
        n_receiving    = r_receiving;
        n_bit_count    = r_bit_count;
        n_packet       = r_packet;
        n_seq_total    = r_seq_total;
        n_seq_count    = r_seq_count;
        n_seq_cmd      = r_seq_cmd;
        n_seq_arg      = r_seq_arg;
        n_player_count = r_player_count;
        n_player_index = r_player_index;
        n_mask         = r_mask;
        o_result       = '0;
        lines          = i_joyp_value[5:4];
        idx            = r_player_index + 2'd1;
        bit_val        = (r_prev_lines == tlpr_pkg::LINES_SEND_ONE);
        bits           = r_packet
                         | ({{(tlpr_pkg::PACKET_BITS-1){1'b0}}, bit_val} << r_bit_count);
        v_total        = r_seq_total;
        v_count        = r_seq_count + 3'd1;

        if (i_opcode == tlpr_pkg::OP_READ) begin
            o_result.read_data = i_joyp_value;
            if (r_enabled && r_player_count >= 3'd2) begin
                // rotate through the active controllers
                n_player_index = (r_player_count == 3'd4) ? idx : {1'b0, ~r_player_index[0]};
                o_result.read_data = {i_joyp_value[7:4],
                                      tlpr_pkg::INDEX_INVERT ^ {2'b00, idx}};
            end
        end else if (r_enabled) begin
            n_prev_lines = lines;
            if (lines == tlpr_pkg::LINES_BOTH_LOW) begin
                n_receiving = 1'b1;
                n_bit_count = '0;
                n_packet    = '0;
            end else if (r_receiving && lines == tlpr_pkg::LINES_BOTH_HIGH
                         && (r_prev_lines == tlpr_pkg::LINES_SEND_ONE
                             || r_prev_lines == tlpr_pkg::LINES_SEND_ZERO)) begin
                if (r_bit_count != tlpr_pkg::LAST_BIT) begin
                    n_bit_count = r_bit_count + 1'b1;
                    n_packet    = bits;
                end else begin
                    o_result.packet_valid  = 1'b1;
                    o_result.packet_low    = bits[63:0];
                    o_result.packet_high   = bits[127:64];
                    o_result.packet_number = r_seq_count;
                    if (r_seq_count == 3'd0) begin
                        v_total   = (bits[2:0] == 3'd0) ? 3'd1 : bits[2:0];
                        n_seq_cmd = bits[7:3];
                        n_seq_arg = bits[15:8];
                    end
                    if (v_count >= v_total) begin
                        o_result.sequence_done = 1'b1;
                        n_seq_count = '0;
                        n_seq_total = '0;
                        if (n_seq_cmd == tlpr_pkg::CMD_MULTI_PLAYER) begin
                            n_player_count = tlpr_pkg::player_count_of(n_seq_arg[1:0]);
                            n_player_index = '0;
                        end else if (n_seq_cmd == tlpr_pkg::CMD_MASK_ENABLE) begin
                            n_mask = n_seq_arg[1:0];
                        end
                    end else begin
                        n_seq_count = v_count;
                        n_seq_total = v_total;
                    end
                    n_receiving = 1'b0;
                    n_bit_count = '0;
                    n_packet    = '0;
                end
            end
        end

        o_result.command_id     = n_seq_cmd;
        o_result.active_players = n_player_count;
        o_result.screen_mask    = n_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_prev_lines   <= tlpr_pkg::LINES_BOTH_HIGH;
            r_receiving    <= 1'b0;
            r_bit_count    <= '0;
            r_packet       <= '0;
            r_seq_total    <= '0;
            r_seq_count    <= '0;
            r_seq_cmd      <= '0;
            r_seq_arg      <= '0;
            r_player_count <= 3'd1;
            r_player_index <= '0;
            r_mask         <= '0;
        end else if (i_cfg_we) begin
            // a change of the enable drops link and player state
            if (i_cfg_wdata != r_enabled) begin
                r_enabled      <= i_cfg_wdata;
                r_prev_lines   <= tlpr_pkg::LINES_BOTH_HIGH;
                r_receiving    <= 1'b0;
                r_bit_count    <= '0;
                r_seq_total    <= '0;
                r_seq_count    <= '0;
                r_player_count <= 3'd1;
                r_player_index <= '0;
            end
        end else if (i_take) begin
            r_prev_lines   <= n_prev_lines;
            r_receiving    <= n_receiving;
            r_bit_count    <= n_bit_count;
            r_packet       <= n_packet;
            r_seq_total    <= n_seq_total;
            r_seq_count    <= n_seq_count;
            r_seq_cmd      <= n_seq_cmd;
            r_seq_arg      <= n_seq_arg;
            r_player_count <= n_player_count;
            r_player_index <= n_player_index;
            r_mask         <= n_mask;
        end
    end

endmodule

FILE: hdl/two_line_pulse_packet_receiver.sv
// Two-line pulse packet receiver: handshake and result register.
// Instantiates tlpr_core; depends on tlpr_pkg and the assertion macro header.
//
// Usage: every joypad port access is one input transfer (i_opcode 0 = write,
// 1 = read, i_joyp_value = written or base read value). Each transfer gives
// exactly one result transfer: the read value (controller index substituted
// if enabled with 2 or more players), or for a write the packet outputs when
// the write finished a 128-bit packet, plus the current command, player count
// and mask mode. o_out_valid rises in the cycle after the input transfer.
// Throughput is one item per cycle unless stalled: the state update for an
// item is a single registered step in tlpr_core, and the result register
// accepts the next item in the same cycle as the previous result is taken.
// When the receiver stalls (i_out_ready low with a result held), o_in_ready
// drops and the held result stays unchanged. Reset (i_rst_n low, synchronous)
// empties the result register and restores the disabled, one-player state.
// i_cfg_we writes the enable bit; write it only while idle.
`timescale 1ns / 1ps
`include "two_line_pulse_packet_receiver_macros.svh"

module two_line_pulse_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_joyp_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_packet_valid,
    output logic [63:0] o_packet_low,
    output logic [63:0] o_packet_high,
    output logic [2:0]  o_packet_number,
    output logic        o_sequence_done,
    output logic [4:0]  o_command_id,
    output logic [2:0]  o_active_players,
    output logic [1:0]  o_screen_mask
);

    logic              take;
    logic              r_out_valid;
    tlpr_pkg::t_result core_result;
    tlpr_pkg::t_result r_result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    tlpr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_take       (take),
        .i_opcode     (i_opcode),
        .i_joyp_value (i_joyp_value),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload until its transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_result.read_data;
    assign o_packet_valid   = r_result.packet_valid;
    assign o_packet_low     = r_result.packet_low;
    assign o_packet_high    = r_result.packet_high;
    assign o_packet_number  = r_result.packet_number;
    assign o_sequence_done  = r_result.sequence_done;
    assign o_command_id     = r_result.command_id;
    assign o_active_players = r_result.active_players;
    assign o_screen_mask    = r_result.screen_mask;

    `TLPR_ASSERT_NOW(a_stall_blocks_input, r_out_valid && !i_out_ready, !o_in_ready, "stalled result would be overwritten")
    `TLPR_ASSERT_NEXT(a_take_gives_result, take, r_out_valid, "accepted item produced no result")
    `TLPR_ASSERT_NOW(a_done_needs_packet, r_out_valid && o_sequence_done, o_packet_valid && o_read_data == 8'd0, "sequence end without a packet")
    `TLPR_ASSERT_NOW(a_player_count_legal, r_out_valid, o_active_players == 3'd1 || o_active_players == 3'd2 || o_active_players == 3'd4, "illegal player count")

endmodule

FILE: dv/two_line_pulse_packet_receiver_tb.sv
// Self-checking testbench for two_line_pulse_packet_receiver: drives joypad port
// accesses, predicts each result in lockstep and compares every field.
// Depends on tlpr_pkg and the receiver RTL only.
`timescale 1ns / 1ps

module two_line_pulse_packet_receiver_tb;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int IDLE_WAIT   = 4;
    localparam int PHASE_LEN   = 200;

    localparam logic [1:0] PLAYERS_CODE_ONE   = 2'd0;
    localparam logic [1:0] PLAYERS_CODE_TWO   = 2'd1;
    localparam logic [1:0] PLAYERS_CODE_UNDEF = 2'd2;
    localparam logic [1:0] PLAYERS_CODE_FOUR  = 2'd3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_wdata  = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_opcode     = tlpr_pkg::OP_WRITE;
    logic [7:0]  i_joyp_value = 8'h00;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_read_data;
    logic        o_packet_valid;
    logic [63:0] o_packet_low;
    logic [63:0] o_packet_high;
    logic [2:0]  o_packet_number;
    logic        o_sequence_done;
    logic [4:0]  o_command_id;
    logic [2:0]  o_active_players;
    logic [1:0]  o_screen_mask;

    // Receiver state as predicted from the accepted transfers
    logic         rx_enabled = 1'b0;
    logic [1:0]   line_state = tlpr_pkg::LINES_BOTH_HIGH;
    logic         in_packet  = 1'b0;
    logic [6:0]   bits_taken = '0;
    logic [127:0] frame      = '0;
    logic [2:0]   seq_len    = '0;
    logic [2:0]   seq_pos    = '0;
    logic [4:0]   seq_cmd    = '0;
    logic [7:0]   seq_arg    = '0;
    logic [2:0]   players    = 3'd1;
    logic [1:0]   next_pad   = '0;
    logic [1:0]   mask_sel   = '0;

    tlpr_pkg::t_result pending_results[$];
    tlpr_pkg::t_result got_result;
    logic    in_ready_s  = 1'b0;
    logic    out_valid_s = 1'b0;

    int sent_count  = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    two_line_pulse_packet_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_joyp_value     (i_joyp_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_packet_valid   (o_packet_valid),
        .o_packet_low     (o_packet_low),
        .o_packet_high    (o_packet_high),
        .o_packet_number  (o_packet_number),
        .o_sequence_done  (o_sequence_done),
        .o_command_id     (o_command_id),
        .o_active_players (o_active_players),
        .o_screen_mask    (o_screen_mask)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL two_line_pulse_packet_receiver");
            $finish;
        end
    end

    // Outputs settle well before the falling edge; sample them there
    always @(negedge i_clk) begin
        in_ready_s                <= o_in_ready;
        out_valid_s               <= o_out_valid;
        got_result.read_data      <= o_read_data;
        got_result.packet_valid   <= o_packet_valid;
        got_result.packet_low     <= o_packet_low;
        got_result.packet_high    <= o_packet_high;
        got_result.packet_number  <= o_packet_number;
        got_result.sequence_done  <= o_sequence_done;
        got_result.command_id     <= o_command_id;
        got_result.active_players <= o_active_players;
        got_result.screen_mask    <= o_screen_mask;
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: i_out_ready read here is still the value the DUT saw at this edge
    always @(posedge i_clk) begin
        tlpr_pkg::t_result want;
        if (i_rst_n && out_valid_s && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expected result");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", 64'(want.read_data), 64'(got_result.read_data));
                check_field("packet_valid", 64'(want.packet_valid),
                            64'(got_result.packet_valid));
                check_field("packet_low", want.packet_low, got_result.packet_low);
                check_field("packet_high", want.packet_high, got_result.packet_high);
                check_field("packet_number", 64'(want.packet_number),
                            64'(got_result.packet_number));
                check_field("sequence_done", 64'(want.sequence_done),
                            64'(got_result.sequence_done));
                check_field("command_id", 64'(want.command_id), 64'(got_result.command_id));
                check_field("active_players", 64'(want.active_players),
                            64'(got_result.active_players));
                check_field("screen_mask", 64'(want.screen_mask),
                            64'(got_result.screen_mask));
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic predict_port_access(input logic op, input logic [7:0] val,
                                       output tlpr_pkg::t_result r);
        logic [1:0] lines;
        logic [1:0] pad;
        logic [2:0] len_field;
        r = '0;
        if (op == tlpr_pkg::OP_READ) begin
            r.read_data = val;
            if (rx_enabled && players >= 3'd2) begin
                pad = next_pad + 2'd1;
                next_pad = 2'((int'(next_pad) + 1) % int'(players));
                r.read_data = {val[7:4], tlpr_pkg::INDEX_INVERT ^ {2'b00, pad}};
            end
        end else if (rx_enabled) begin
            lines = val[5:4];
            if (lines == tlpr_pkg::LINES_BOTH_LOW) begin
                in_packet  = 1'b1;
                bits_taken = '0;
                frame      = '0;
            end else if (in_packet && lines == tlpr_pkg::LINES_BOTH_HIGH &&
                         (line_state == tlpr_pkg::LINES_SEND_ONE ||
                          line_state == tlpr_pkg::LINES_SEND_ZERO)) begin
                if (line_state == tlpr_pkg::LINES_SEND_ONE)
                    frame[bits_taken] = 1'b1;
                if (bits_taken != tlpr_pkg::LAST_BIT) begin
                    bits_taken = bits_taken + 7'd1;
                end else begin
                    r.packet_valid  = 1'b1;
                    r.packet_low    = frame[63:0];
                    r.packet_high   = frame[127:64];
                    r.packet_number = seq_pos;
                    // First packet of a sequence carries length, command and argument
                    if (seq_pos == 3'd0) begin
                        len_field = frame[2:0];
                        seq_len   = (len_field == 3'd0) ? 3'd1 : len_field;
                        seq_cmd   = frame[7:3];
                        seq_arg   = frame[15:8];
                    end
                    seq_pos = seq_pos + 3'd1;
                    if (seq_pos >= seq_len) begin
                        if (seq_cmd == tlpr_pkg::CMD_MULTI_PLAYER) begin
                            case (seq_arg[1:0])
                                PLAYERS_CODE_TWO:  players = 3'd2;
                                PLAYERS_CODE_FOUR: players = 3'd4;
                                default:           players = 3'd1;
                            endcase
                            next_pad = '0;
                        end else if (seq_cmd == tlpr_pkg::CMD_MASK_ENABLE) begin
                            mask_sel = seq_arg[1:0];
                        end
                        r.sequence_done = 1'b1;
                        seq_pos = '0;
                        seq_len = '0;
                    end
                    in_packet  = 1'b0;
                    bits_taken = '0;
                    frame      = '0;
                end
            end
            line_state = lines;
        end
        r.command_id     = seq_cmd;
        r.active_players = players;
        r.screen_mask    = mask_sel;
    endtask

    task automatic drive_access(input logic op, input logic [7:0] val);
        tlpr_pkg::t_result r;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_joyp_value <= val;
        @(posedge i_clk);
        while (!in_ready_s)
            @(posedge i_clk);
        predict_port_access(op, val, r);
        pending_results.push_back(r);
        sent_count++;
        case ((sent_count / PHASE_LEN) % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 71; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 71; end
            default: begin gap_pct = 7;  stall_pct = 7;  end
        endcase
    endtask

    task automatic set_receiver_enable(input logic v);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // Any change of the enable drops reception and the player setup
        if (v != rx_enabled) begin
            rx_enabled = v;
            line_state = tlpr_pkg::LINES_BOTH_HIGH;
            in_packet  = 1'b0;
            bits_taken = '0;
            seq_len    = '0;
            seq_pos    = '0;
            players    = 3'd1;
            next_pad   = '0;
        end
    endtask

    task automatic send_write(input logic [1:0] lines);
        logic [7:0] v;
        v = 8'($urandom);
        v[5:4] = lines;
        drive_access(tlpr_pkg::OP_WRITE, v);
    endtask

    // Start pulse, then n_bits pulses LSB first; a short count leaves the packet open
    task automatic send_frame(input logic [127:0] payload, input int n_bits);
        int pick;
        send_write(tlpr_pkg::LINES_BOTH_LOW);
        for (int i = 0; i < n_bits; i++) begin
            if ($urandom_range(99) < 8) begin
                pick = $urandom_range(9);
                if (pick < 6)
                    drive_access(tlpr_pkg::OP_READ, 8'($urandom));
                else if (pick < 8)
                    send_write(tlpr_pkg::LINES_BOTH_HIGH);
                else
                    send_write(payload[i] ? tlpr_pkg::LINES_SEND_ZERO
                                          : tlpr_pkg::LINES_SEND_ONE);
            end
            send_write(payload[i] ? tlpr_pkg::LINES_SEND_ONE : tlpr_pkg::LINES_SEND_ZERO);
            send_write(tlpr_pkg::LINES_BOTH_HIGH);
        end
    endtask

    task automatic send_command_sequence(input logic [4:0] cmd, input logic [7:0] arg,
                                         input logic [2:0] len_field);
        logic [127:0] payload;
        int           n_packets;
        n_packets = (len_field == 3'd0) ? 1 : int'(len_field);
        for (int p = 0; p < n_packets; p++) begin
            payload = {$urandom, $urandom, $urandom, $urandom};
            if (p == 0) begin
                payload[7:0]  = {cmd, len_field};
                payload[15:8] = arg;
            end
            // Now and then abandon a packet partway and start it over
            if ($urandom_range(7) == 0)
                send_frame(payload, $urandom_range(127, 1));
            send_frame(payload, 128);
        end
    endtask

    task automatic test_disabled_port();
        set_receiver_enable(1'b0);
        drive_access(tlpr_pkg::OP_READ, 8'h00);
        drive_access(tlpr_pkg::OP_READ, 8'hFF);
        drive_access(tlpr_pkg::OP_WRITE, 8'h00);
        drive_access(tlpr_pkg::OP_WRITE, 8'h10);
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);
        drive_access(tlpr_pkg::OP_WRITE, 8'hFF);
    endtask

    task automatic test_single_player_reads();
        set_receiver_enable(1'b1);
        drive_access(tlpr_pkg::OP_READ, 8'h00);
        drive_access(tlpr_pkg::OP_READ, 8'hFF);
        drive_access(tlpr_pkg::OP_READ, 8'h5A);
    endtask

    task automatic test_line_special_cases();
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);  // high while idle
        drive_access(tlpr_pkg::OP_WRITE, 8'h10);  // pulse while idle
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);  // return to high while idle: no bit
        drive_access(tlpr_pkg::OP_WRITE, 8'h00);  // start
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);  // high right after both low: no bit
        drive_access(tlpr_pkg::OP_WRITE, 8'hF0);  // high after high: no bit
        drive_access(tlpr_pkg::OP_WRITE, 8'h1F);
        drive_access(tlpr_pkg::OP_WRITE, 8'hFF);  // takes a one
        drive_access(tlpr_pkg::OP_WRITE, 8'h20);
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);  // takes a zero
        drive_access(tlpr_pkg::OP_WRITE, 8'h10);
        drive_access(tlpr_pkg::OP_WRITE, 8'h00);  // start in mid packet
        drive_access(tlpr_pkg::OP_WRITE, 8'hCF);  // both low with other bits set
        drive_access(tlpr_pkg::OP_WRITE, 8'hEF);
        drive_access(tlpr_pkg::OP_WRITE, 8'h30);
    endtask

    task automatic test_command_sequences(input int budget);
        logic [1:0] codes [4];
        logic [4:0] cmd;
        logic [7:0] arg;
        logic [2:0] len_field;
        int         stop_at;
        int         seq_no;
        int         r;
        codes = '{PLAYERS_CODE_FOUR, PLAYERS_CODE_TWO, PLAYERS_CODE_UNDEF, PLAYERS_CODE_ONE};
        stop_at = sent_count + budget;
        seq_no  = 0;
        while (sent_count < stop_at) begin
            arg = 8'($urandom);
            case (seq_no % 3)
                0: begin
                    cmd      = tlpr_pkg::CMD_MULTI_PLAYER;
                    arg[1:0] = codes[(seq_no / 3) % 4];
                end
                1:       cmd = tlpr_pkg::CMD_MASK_ENABLE;
                default: cmd = 5'($urandom);
            endcase
            r = $urandom_range(9);
            len_field = (r == 0) ? 3'd0 : (r <= 6) ? 3'd1 : (r <= 8) ? 3'd2 : 3'd3;
            send_command_sequence(cmd, arg, len_field);
            seq_no++;
            // walk the controller index
            repeat ($urandom_range(6)) drive_access(tlpr_pkg::OP_READ, 8'($urandom));
        end
    endtask

    task automatic test_enable_change();
        logic [7:0] arg;
        arg = 8'($urandom);
        arg[1:0] = PLAYERS_CODE_FOUR;
        send_command_sequence(tlpr_pkg::CMD_MULTI_PLAYER, arg, 3'd1);
        repeat (6) drive_access(tlpr_pkg::OP_READ, 8'($urandom));
        send_frame({$urandom, $urandom, $urandom, $urandom}, $urandom_range(40, 8));
        set_receiver_enable(1'b0);
        repeat (8) drive_access(1'($urandom), 8'($urandom));
        set_receiver_enable(1'b0);
        set_receiver_enable(1'b1);
        repeat (4) drive_access(tlpr_pkg::OP_READ, 8'($urandom));
        send_write(tlpr_pkg::LINES_BOTH_HIGH);
        send_command_sequence(tlpr_pkg::CMD_MASK_ENABLE, 8'($urandom), 3'd0);
        repeat (4) drive_access(tlpr_pkg::OP_READ, 8'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_port();
        test_single_player_reads();
        test_line_special_cases();
        test_command_sequences(1000);
        test_enable_change();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS two_line_pulse_packet_receiver");
        else
            $display("FAIL two_line_pulse_packet_receiver");
        $finish;
    end

endmodule
